FILE: rtl/gmps_pkg.sv
package gmps_pkg;

    // fixed field widths
    localparam int CELL_VALUE_BITS = 16;
    localparam int SUM_BITS        = 27;
    localparam int CFG_DATA_BITS   = 11;
    localparam int CFG_INDEX_BITS  = 2;

    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    // parameter defaults
    localparam int DEF_MAX_COLS  = 1024;
    localparam int DEF_MAX_ROWS  = 1024;
    localparam int DEF_CELL_BITS = 16;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_ROWS = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_COLS = CFG_INDEX_BITS'(1);

    // where a cell sits in its grid
    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last;
    } pos_t;

endpackage

FILE: rtl/gmps_if.sv
interface gmps_cell_if import gmps_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CELL_VALUE_BITS-1:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

interface gmps_sum_if import gmps_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SUM_BITS-1:0] min_sum;

    modport source (output valid, output min_sum, input ready);
    modport sink   (input valid, input min_sum, output ready);
endinterface

FILE: rtl/gmps_ram.sv
module gmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read of the entry being written returns the old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/gmps_seq.sv
module gmps_seq import gmps_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                        advance,
    output logic [$clog2(MAX_COLS)-1:0] col,
    output pos_t                        pos
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] last_col_reg, last_col_next;
    logic [RW-1:0] last_row_reg, last_row_next;
    logic [CW-1:0] cfg_last_col;
    logic [RW-1:0] cfg_last_row;
    logic          cfg_hit;

    // size 0 counts as 1, oversize clamps to the maximum
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_last_col = '0;
            cfg_last_row = '0;
        end
        else
        begin
            if (32'(cfg_data) > 32'(MAX_COLS))
            begin
                cfg_last_col = CW'(MAX_COLS - 1);
            end
            else
            begin
                cfg_last_col = CW'(cfg_data - CFG_DATA_BITS'(1));
            end
            if (32'(cfg_data) > 32'(MAX_ROWS))
            begin
                cfg_last_row = RW'(MAX_ROWS - 1);
            end
            else
            begin
                cfg_last_row = RW'(cfg_data - CFG_DATA_BITS'(1));
            end
        end
    end

    assign cfg_hit = cfg_we && (cfg_index == REG_GRID_ROWS || cfg_index == REG_GRID_COLS);

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
            if (cfg_index == REG_GRID_ROWS)
            begin
                last_row_next = cfg_last_row;
            end
            else
            begin
                last_col_next = cfg_last_col;
            end
        end
        else if (advance)
        begin
            if (col_reg == last_col_reg)
            begin
                col_next = '0;
                row_next = (row_reg == last_row_reg) ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            last_col_reg <= '0;
            last_row_reg <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
        end
    end

    assign col           = col_reg;
    assign pos.first_row = (row_reg == '0);
    assign pos.first_col = (col_reg == '0);
    assign pos.last      = (col_reg == last_col_reg) && (row_reg == last_row_reg);

endmodule

FILE: rtl/grid_min_path_sum.sv
// Channel   Dir  Payload                 Handshake
// cell_in   in   cell_value[15:0]        valid/ready, one cell, row-major
// sum_out   out  min_sum[26:0]           valid/ready, one item per grid
// cfg       in   cfg_index, cfg_data     cfg_we, no stall
//
// One cell per cycle sustained. A cell enters at acceptance, which issues the
// row buffer read and loads the compute stage; there it is added to the best
// neighbor and written back, and a grid's last sum goes to the output register.
// Input stalls only while a finished result waits in the output register and
// another grid-closing cell is ready to land on it.
// Reset clears control state and sets a 1x1 grid; the row buffer is not cleared.
module grid_min_path_sum import gmps_pkg::*; #(
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int CELL_BITS = DEF_CELL_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    gmps_cell_if.sink                 cell_in,
    gmps_sum_if.source                sum_out
);

    localparam int CW = $clog2(MAX_COLS);
    localparam logic [CELL_VALUE_BITS-1:0] CELL_MASK =
        (CELL_BITS >= CELL_VALUE_BITS) ? '1
                                       : CELL_VALUE_BITS'((64'd1 << CELL_BITS) - 64'd1);

    // entry side
    logic          accept;
    logic [CW-1:0] s0_col;
    pos_t          s0_pos;

    // compute stage
    logic                       s1_valid_reg, s1_valid_next;
    pos_t                       s1_pos_reg;
    logic [CW-1:0]              s1_col_reg;
    logic [CELL_VALUE_BITS-1:0] s1_val_reg;
    logic                       s1_fwd_reg, s1_fwd_next;
    logic                       s1_go;
    logic                       s1_fire;

    logic [SUM_BITS-1:0] left_reg;
    logic [SUM_BITS-1:0] above_raw;
    logic [SUM_BITS-1:0] above;
    logic [SUM_BITS-1:0] base;
    logic [SUM_BITS:0]   sum_wide;
    logic [SUM_BITS-1:0] best;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [SUM_BITS-1:0] out_sum_reg;

    // a grid-closing cell can only move on if the output register will be free
    assign s1_go   = !(s1_valid_reg && s1_pos_reg.last && out_valid_reg && !sum_out.ready);
    assign s1_fire = s1_valid_reg && s1_go;

    assign cell_in.ready = s1_go;
    assign accept        = cell_in.valid && cell_in.ready;

    gmps_seq #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .col       (s0_col),
        .pos       (s0_pos)
    );

    // previous row's best sums, one entry per column
    gmps_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (MAX_COLS)
    ) u_row_best (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_col_reg),
        .wdata (best),
        .re    (accept),
        .raddr (s0_col),
        .rdata (above_raw)
    );

    // Single-column grid: the read of a column lands on the same edge as the
    // write of that column, so the RAM returns stale data. Flag it and take
    // the left register, which holds exactly that written value.
    assign s1_fwd_next   = s1_fire && (s1_col_reg == s0_col);
    assign s1_valid_next = accept || (s1_valid_reg && !s1_go);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                s1_fwd_reg <= s1_fwd_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg <= s0_pos;
            s1_col_reg <= s0_col;
            s1_val_reg <= cell_in.cell_value & CELL_MASK;
        end
    end

    assign above = s1_fwd_reg ? left_reg : above_raw;

    // best neighbor: none at top-left, left on the first row, above on the
    // first column, the smaller of the two elsewhere
    always_comb
    begin
        if (s1_pos_reg.first_row && s1_pos_reg.first_col)
        begin
            base = '0;
        end
        else if (s1_pos_reg.first_row)
        begin
            base = left_reg;
        end
        else if (s1_pos_reg.first_col)
        begin
            base = above;
        end
        else
        begin
            base = (left_reg < above) ? left_reg : above;
        end
    end

    assign sum_wide = {1'b0, base} + (SUM_BITS + 1)'(s1_val_reg);
    assign best     = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else if (s1_fire)
        begin
            left_reg <= best;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !sum_out.ready;
        if (s1_fire && s1_pos_reg.last)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_pos_reg.last)
        begin
            out_sum_reg <= best;
        end
    end

    assign sum_out.valid   = out_valid_reg;
    assign sum_out.min_sum = out_sum_reg;

    // input only stalls behind a blocked grid-closing cell
    assert property (@(posedge clk) disable iff (!rst_n)
        !cell_in.ready |-> s1_valid_reg && s1_pos_reg.last && out_valid_reg)
        else $error("input stalled without a blocked result");

    // forwarding in a live compute stage only happens on the first column
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fwd_reg && s1_valid_reg |-> s1_pos_reg.first_col)
        else $error("forward taken away from the first column");

    // a closing cell lands its sum in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_pos_reg.last |=> out_valid_reg && out_sum_reg == $past(best))
        else $error("result not loaded");

    // a blocked result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !sum_out.ready |=> out_valid_reg && $stable(out_sum_reg))
        else $error("pending result lost");

endmodule

FILE: sim/tb_grid_min_path_sum.sv
module tb_grid_min_path_sum;
    import gmps_pkg::*;

    // Index with no register behind it; a write there must leave the grid alone.
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = CFG_INDEX_BITS'(2);

    // How cell values are chosen for a grid.
    localparam int FILL_ANY  = 0;   // full 16-bit range
    localparam int FILL_LOW  = 1;   // 0..7, lots of ties between neighbors
    localparam int FILL_EDGE = 2;   // only 0 or all ones
    localparam int FILL_HIGH = 3;   // at or just under the top
    localparam int FILL_TOP  = 4;   // all ones

    localparam int RANDOM_CELLS = 740;
    localparam int CALM_TAIL    = 150;   // last cells run with no idling
    localparam int SETTLE_LAG   = 4;
    localparam int DRAIN_LAG    = 8;
    localparam int HANG_LIMIT   = 1000;  // cycles with no item moving

    // Tracks the running min path sum; one expected min_sum per finished grid.
    class path_sum_board;
        logic [SUM_BITS-1:0]      row_best [DEF_MAX_COLS];
        logic [SUM_BITS-1:0]      left_best;
        int unsigned              next_row;
        int unsigned              next_col;
        logic [CFG_DATA_BITS-1:0] rows_reg;
        logic [CFG_DATA_BITS-1:0] cols_reg;
        logic [SUM_BITS-1:0]      sums_due [$];
        int unsigned              errors;

        function new();
            foreach (row_best[i])
                row_best[i] = '0;
            left_best = '0;
            next_row  = 0;
            next_col  = 0;
            rows_reg  = CFG_DATA_BITS'(1);
            cols_reg  = CFG_DATA_BITS'(1);
            errors    = 0;
        endfunction

        // 0 means 1, anything past the buffer size means the buffer size
        static function int unsigned clamp_dim(logic [CFG_DATA_BITS-1:0] v, int unsigned cap);
            if (v == 0)
                return 1;
            if (v > cap)
                return cap;
            return 32'(v);
        endfunction

        static function logic [SUM_BITS-1:0] add_capped(logic [SUM_BITS-1:0] a,
                                                      logic [CELL_VALUE_BITS-1:0] b);
            logic [SUM_BITS:0] s;
            s = {1'b0, a} + (SUM_BITS + 1)'(b);
            if (s > SUM_MAX)
                return SUM_MAX;
            return s[SUM_BITS-1:0];
        endfunction

        function int unsigned grid_cells();
            return clamp_dim(rows_reg, DEF_MAX_ROWS) * clamp_dim(cols_reg, DEF_MAX_COLS);
        endfunction

        function void note_config(logic [CFG_INDEX_BITS-1:0] idx,
                                  logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_GRID_ROWS: rows_reg = data;
                REG_GRID_COLS: cols_reg = data;
                default: return;
            endcase
            // any real register write drops the grid in progress
            next_row = 0;
            next_col = 0;
        endfunction

        function void note_cell(logic [CELL_VALUE_BITS-1:0] v);
            int unsigned         rows;
            int unsigned         cols;
            int unsigned         r;
            int unsigned         c;
            logic [SUM_BITS-1:0] above;
            logic [SUM_BITS-1:0] base;
            logic [SUM_BITS-1:0] best;
            rows = clamp_dim(rows_reg, DEF_MAX_ROWS);
            cols = clamp_dim(cols_reg, DEF_MAX_COLS);
            r = next_row;
            c = next_col;
            if (c >= cols || r >= rows)
            begin
                r = 0;
                c = 0;
            end
            above = row_best[c];
            if (r == 0 && c == 0)
                base = '0;
            else if (r == 0)
                base = left_best;
            else if (c == 0)
                base = above;
            else
                base = (left_best < above) ? left_best : above;
            best = add_capped(base, v);
            row_best[c] = best;
            left_best   = best;
            if (c + 1 == cols && r + 1 == rows)
            begin
                next_row = 0;
                next_col = 0;
                sums_due.push_back(best);
            end
            else if (c + 1 == cols)
            begin
                next_col = 0;
                next_row = r + 1;
            end
            else
            begin
                next_col = c + 1;
                next_row = r;
            end
        endfunction

        function void check_min_sum(logic [SUM_BITS-1:0] got);
            logic [SUM_BITS-1:0] want;
            if (sums_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("min_sum %0d arrived with no grid finished", got);
                return;
            end
            want = sums_due.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("min_sum mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    gmps_cell_if cell_ch ();
    gmps_sum_if  sum_ch ();

    path_sum_board board;

    // percent chance of starting an idle burst: per item on the cell side,
    // per cycle on the result side
    int unsigned src_odds  = 0;
    int unsigned sink_odds = 0;

    int unsigned quiet_cycles = 0;
    int unsigned sink_hold = 0;

    grid_min_path_sum DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cell_in   (cell_ch),
        .sum_out   (sum_ch)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Monitor: both channels are sampled at the rising edge. Accepted cells
    // feed the predictor, accepted sums are checked against the oldest one due.
    // The same edge drives the hang watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles++;
            if (cell_ch.valid === 1'b1 && cell_ch.ready === 1'b1)
            begin
                board.note_cell(cell_ch.cell_value);
                quiet_cycles = 0;
            end
            if (sum_ch.valid === 1'b1 && sum_ch.ready === 1'b1)
            begin
                board.check_min_sum(sum_ch.min_sum);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("tb_grid_min_path_sum: done, errors");
                $finish;
            end
        end
    end

    // Result side back-pressure: random stall bursts.
    always @(negedge clk)
    begin
        if (!rst_n)
            sum_ch.ready <= 1'b0;
        else if (sink_hold != 0)
        begin
            sum_ch.ready <= 1'b0;
            sink_hold--;
        end
        else if (sink_odds != 0 && $urandom_range(1, 100) <= sink_odds)
        begin
            sum_ch.ready <= 1'b0;
            sink_hold = $urandom_range(0, 11);
        end
        else
            sum_ch.ready <= 1'b1;
    end

    function automatic logic [CELL_VALUE_BITS-1:0] pick_cell(int mode);
        case (mode)
            FILL_LOW:  return CELL_VALUE_BITS'($urandom_range(0, 7));
            FILL_EDGE: return $urandom_range(0, 1) ? '1 : '0;
            FILL_HIGH: return CELL_VALUE_BITS'(16'hFFFF - $urandom_range(0, 3));
            FILL_TOP:  return '1;
            default:   return CELL_VALUE_BITS'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // All driving tasks start and end on a falling edge.
    task automatic push_cell(logic [CELL_VALUE_BITS-1:0] v);
        int gap;
        if (src_odds != 0 && $urandom_range(1, 100) <= src_odds)
        begin
            gap = $urandom_range(1, 12);
            cell_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cell_ch.valid      <= 1'b1;
        cell_ch.cell_value <= v;
        @(posedge clk);
        while (cell_ch.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic feed_grid(int unsigned count, int mode);
        for (int unsigned i = 0; i < count; i++)
            push_cell(pick_cell(mode));
    endtask

    // Hold the sender until every finished grid has reported, then wait out
    // SETTLE_LAG so the pipeline can flush any cell that completes no grid.
    task automatic settle();
        cell_ch.valid <= 1'b0;
        while (board.sums_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_LAG) @(negedge clk);
    endtask

    // Leaves one low cycle on cfg_we so back-to-back writes never collide.
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.note_config(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_grid(logic [CFG_DATA_BITS-1:0] rows, logic [CFG_DATA_BITS-1:0] cols);
        settle();
        write_reg(REG_GRID_ROWS, rows);
        write_reg(REG_GRID_COLS, cols);
    endtask

    initial
    begin
        int unsigned              sent;
        int unsigned              count;
        int                       mode;
        bit                       must_write;
        logic [CFG_DATA_BITS-1:0] rows;
        logic [CFG_DATA_BITS-1:0] cols;

        board = new();
        cell_ch.valid      = 1'b0;
        cell_ch.cell_value = '0;
        sum_ch.ready       = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part ----
        // reset grid is 1x1: every cell is its own result
        push_cell(16'hFFFF);
        push_cell(16'h0000);

        // 2x3 where the cheap path has to bend around the expensive cell
        set_grid(2, 3);
        push_cell(16'd5);
        push_cell(16'd1);
        push_cell(16'd9);
        push_cell(16'd2);
        push_cell(16'hFFFF);
        push_cell(16'd3);

        // zero sizes act as 1
        set_grid(0, 0);
        push_cell(16'd7);
        push_cell(16'hAAAA);

        // write to an index with no register: nothing should change
        settle();
        write_reg(REG_SPARE, 11'h555);

        // abandon a grid halfway through: rewriting a register restarts it
        set_grid(3, 2);
        feed_grid(3, FILL_ANY);
        settle();
        write_reg(REG_GRID_COLS, 2);
        feed_grid(6, FILL_ANY);

        // alternating and solid bit patterns on a 2x2
        set_grid(2, 2);
        push_cell(16'h5555);
        push_cell(16'hAAAA);
        push_cell(16'hFFFF);
        push_cell(16'h0000);

        // all-ones cells on a square grid under stalls
        src_odds  = 5;
        sink_odds = 20;
        set_grid(6, 6);
        feed_grid(board.grid_cells(), FILL_TOP);

        // ---- random part ----
        // Mostly small grids, streamed back to back when the size is kept so
        // results pile up against a stalled receiver. Now and then a grid is
        // cut short and abandoned by a register write.
        sent = 0;
        must_write = 1'b1;
        while (sent < RANDOM_CELLS)
        begin
            if (sent + CALM_TAIL >= RANDOM_CELLS)
            begin
                src_odds  = 0;
                sink_odds = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: src_odds = 0;
                    1: src_odds = 5;
                    default: src_odds = 30;
                endcase
                case ($urandom_range(0, 2))
                    0: sink_odds = 0;
                    1: sink_odds = 10;
                    default: sink_odds = 40;
                endcase
            end

            if (must_write || $urandom_range(0, 1))
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    rows = CFG_DATA_BITS'($urandom_range(0, 16));
                    cols = CFG_DATA_BITS'($urandom_range(0, 16));
                end
                else
                begin
                    rows = CFG_DATA_BITS'($urandom_range(0, 6));
                    cols = CFG_DATA_BITS'($urandom_range(0, 6));
                end
                set_grid(rows, cols);
                must_write = 1'b0;
            end

            mode  = $urandom_range(FILL_ANY, FILL_HIGH);
            count = board.grid_cells();
            if (count > 1 && $urandom_range(0, 9) == 0)
            begin
                count = $urandom_range(1, count - 1);
                must_write = 1'b1;
            end
            // a few grids in a row under one size setting
            for (int g = $urandom_range(1, 3);
                 g > 0 && !must_write && sent < RANDOM_CELLS; g--)
            begin
                feed_grid(count, mode);
                sent += count;
            end
            if (must_write)
            begin
                feed_grid(count, mode);
                sent += count;
            end
        end

        // ---- drain ----
        cell_ch.valid <= 1'b0;
        while (board.sums_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_LAG) @(negedge clk);

        if (board.errors == 0 && board.sums_due.size() == 0)
            $display("tb_grid_min_path_sum: done, clean");
        else
            $display("tb_grid_min_path_sum: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/gmps_pkg.sv
rtl/gmps_if.sv
rtl/gmps_ram.sv
rtl/gmps_seq.sv
rtl/grid_min_path_sum.sv
sim/tb_grid_min_path_sum.sv
